@@ rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define AST_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define AST_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/ptw_pkg.sv @@
// Package with types and constants of the page table walker.
`timescale 1ns / 1ps
package ptw_pkg;

  localparam int POOL_FRAMES       = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int FRAME_W           = $clog2(POOL_FRAMES);
  localparam int NFF_W             = $clog2(POOL_FRAMES + 1);
  localparam int DEPTH             = POOL_FRAMES * ENTRIES_PER_TABLE;
  localparam int ADDR_W            = $clog2(DEPTH);
  localparam int PAGE_W            = 40;

  localparam int BIT_P  = 0;
  localparam int BIT_W  = 1;
  localparam int BIT_PS = 7;

  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_HUGE       = 3'd1;
  localparam logic [2:0] ST_UNMAPPED   = 3'd2;
  localparam logic [2:0] ST_HUGE_BLOCK = 3'd3;
  localparam logic [2:0] ST_NO_FRAMES  = 3'd4;
  localparam logic [2:0] ST_BAD_PTR    = 3'd5;

  localparam logic CMD_MAP   = 1'b0;
  localparam logic CMD_UNMAP = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [47:0] vaddr;
    logic [51:0] paddr;
    logic [63:0] flags;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [51:0] old_phys;
    logic        invalidate;
    logic [47:0] invalidate_addr;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EV,
    S_PT,
    S_WL
  } state_t;

  typedef struct packed {
    logic       clr_wr;
    logic       load;
    logic       rd;
    logic       cap_entry;
    logic       alloc;
    logic       next_level;
    logic       leaf_map_wr;
    logic       leaf_unmap_wr;
    logic       finish;
    logic [2:0] fin_status;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic is_unmap;
    logic present;
    logic huge;
    logic full;
    logic ptr_ok;
    logic lvl_root;
    logic lvl_last_tbl;
    logic lvl_leaf;
  } stat_t;

endpackage

@@ rtl/page_table_map_unmap_walker_top.sv @@
// Top level of the four-level page table map and unmap walker.
//
// A request is taken when start is high while busy is low; req carries the
// command, virtual address, physical address and leaf flags. One result
// follows each request: rsp is valid in the single cycle in which done is
// high, and the receiver cannot hold it off.
// The table store is one synchronous memory with one read and one write per
// cycle. Each of the three table levels goes through a read, an evaluate and
// a pointer check step. A map then writes the leaf and an unmap reads the
// leaf and clears it; early exits end the walk sooner. One request is in
// flight at a time, and the next one can be taken in the cycle in which done
// is high. The configuration channel (cfg_valid, cfg_ready, cfg_data) writes
// the pool base address and is always ready.
// After reset the block clears the whole table store, one entry per cycle,
// with busy high; configuration writes are still taken.
// Reset also sets the frame allocator to one and the pool base to zero.
`timescale 1ns / 1ps
module page_table_map_unmap_walker_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ptw_pkg::req_t req,
  output logic          done,
  output ptw_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [51:0]   cfg_data
);

  ptw_pkg::ctl_t  ctl;
  ptw_pkg::stat_t stat;

  ptw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  ptw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctl       (ctl),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .done      (done),
    .rsp       (rsp)
  );

endmodule

@@ rtl/ptw_dp.sv @@
// Datapath of the page table walker: table store, walk registers and result.
`timescale 1ns / 1ps
module ptw_dp (
  input  logic          clk,
  input  logic          rst,
  input  ptw_pkg::req_t req,
  input  ptw_pkg::ctl_t ctl,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [51:0]   cfg_data,
  output ptw_pkg::stat_t stat,
  output logic          done,
  output ptw_pkg::rsp_t rsp
);

  logic [63:0] mem [ptw_pkg::DEPTH];
  logic [63:0] rdata;

  logic [ptw_pkg::ADDR_W-1:0]  clr_cnt;
  logic [ptw_pkg::PAGE_W-1:0]  base;
  logic [ptw_pkg::NFF_W-1:0]   nff;
  ptw_pkg::req_t               cur;
  logic [ptw_pkg::FRAME_W-1:0] frame;
  logic [1:0]                  level;
  logic [ptw_pkg::PAGE_W-1:0]  ent_page;

  logic [ptw_pkg::IDX_W-1:0]   idx;
  logic [ptw_pkg::ADDR_W-1:0]  addr;
  logic [ptw_pkg::ADDR_W-1:0]  waddr;
  logic [63:0]                 wdata;
  logic                        we;
  logic [ptw_pkg::PAGE_W-1:0]  new_page;
  logic [ptw_pkg::PAGE_W-1:0]  off;
  logic                        ok_done;

  assign cfg_ready = 1'b1;

  always_comb begin
    case (level)
      2'd0:    idx = cur.vaddr[47:39];
      2'd1:    idx = cur.vaddr[38:30];
      2'd2:    idx = cur.vaddr[29:21];
      default: idx = cur.vaddr[20:12];
    endcase
  end

  assign addr     = {frame, idx};
  assign new_page = base + ptw_pkg::PAGE_W'(nff);
  assign off      = ent_page - base;

  always_comb begin
    we    = 1'b1;
    waddr = addr;
    wdata = '0;
    if (ctl.clr_wr) begin
      waddr = clr_cnt;
    end else if (ctl.alloc) begin
      wdata = {12'b0, new_page, 12'b0};
      wdata[ptw_pkg::BIT_P] = 1'b1;
      wdata[ptw_pkg::BIT_W] = 1'b1;
    end else if (ctl.leaf_map_wr) begin
      wdata = {12'b0, cur.paddr[51:12], 12'b0} | cur.flags;
    end else if (!ctl.leaf_unmap_wr) begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

  always_comb begin
    stat.clr_last     = (clr_cnt == ptw_pkg::ADDR_W'(ptw_pkg::DEPTH - 1));
    stat.is_unmap     = (cur.cmd == ptw_pkg::CMD_UNMAP);
    stat.present      = rdata[ptw_pkg::BIT_P];
    stat.huge         = rdata[ptw_pkg::BIT_PS];
    stat.full         = (nff == ptw_pkg::NFF_W'(ptw_pkg::POOL_FRAMES));
    stat.ptr_ok       = (ent_page >= base)
                        && (off[ptw_pkg::PAGE_W-1:ptw_pkg::NFF_W] == '0)
                        && (off[ptw_pkg::NFF_W-1:0] < nff);
    stat.lvl_root     = (level == 2'd0);
    stat.lvl_last_tbl = (level == 2'd2);
    stat.lvl_leaf     = (level == 2'd3);
  end

  assign ok_done = (ctl.fin_status == ptw_pkg::ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      base    <= '0;
      nff     <= ptw_pkg::NFF_W'(1);
      done    <= 1'b0;
    end else begin
      if (ctl.clr_wr) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        base <= cfg_data[51:12];
      end
      if (ctl.alloc) begin
        nff <= nff + 1'b1;
      end
      done <= ctl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cur   <= req;
      frame <= '0;
      level <= 2'd0;
    end
    if (ctl.cap_entry) begin
      ent_page <= rdata[51:12];
    end
    if (ctl.alloc) begin
      ent_page <= new_page;
    end
    if (ctl.next_level) begin
      frame <= off[ptw_pkg::FRAME_W-1:0];
      level <= level + 2'd1;
    end
    if (ctl.finish) begin
      rsp.status          <= ctl.fin_status;
      rsp.old_phys        <= (ok_done && ctl.leaf_unmap_wr) ? {rdata[51:12], 12'b0} : '0;
      rsp.invalidate      <= ok_done;
      rsp.invalidate_addr <= ok_done ? cur.vaddr : '0;
    end
  end

endmodule

@@ rtl/ptw_ctrl.sv @@
// Controller state machine that sequences the table walk.
`timescale 1ns / 1ps
module ptw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ptw_pkg::stat_t stat,
  output ptw_pkg::ctl_t  ctl,
  output logic           busy
);

  ptw_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptw_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ptw_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ptw_pkg::S_CLEAR: begin
        ctl.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = ptw_pkg::S_IDLE;
        end
      end
      ptw_pkg::S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = ptw_pkg::S_RD;
        end
      end
      ptw_pkg::S_RD: begin
        ctl.rd     = 1'b1;
        state_next = ptw_pkg::S_EV;
      end
      ptw_pkg::S_EV: begin
        state_next = ptw_pkg::S_PT;
        if (stat.is_unmap) begin
          if (!stat.present) begin
            ctl.finish     = 1'b1;
            ctl.fin_status = ptw_pkg::ST_UNMAPPED;
          end else if (stat.lvl_leaf) begin
            ctl.leaf_unmap_wr = 1'b1;
            ctl.finish        = 1'b1;
            ctl.fin_status    = ptw_pkg::ST_DONE;
          end else if (!stat.lvl_root && stat.huge) begin
            ctl.finish     = 1'b1;
            ctl.fin_status = ptw_pkg::ST_HUGE_BLOCK;
          end else begin
            ctl.cap_entry = 1'b1;
          end
        end else begin
          if (!stat.lvl_root && stat.present && stat.huge) begin
            ctl.finish     = 1'b1;
            ctl.fin_status = ptw_pkg::ST_HUGE;
          end else if (!stat.present) begin
            if (stat.full) begin
              ctl.finish     = 1'b1;
              ctl.fin_status = ptw_pkg::ST_NO_FRAMES;
            end else begin
              ctl.alloc = 1'b1;
            end
          end else begin
            ctl.cap_entry = 1'b1;
          end
        end
        if (ctl.finish) begin
          state_next = ptw_pkg::S_IDLE;
        end
      end
      ptw_pkg::S_PT: begin
        if (!stat.ptr_ok) begin
          ctl.finish     = 1'b1;
          ctl.fin_status = ptw_pkg::ST_BAD_PTR;
          state_next     = ptw_pkg::S_IDLE;
        end else begin
          ctl.next_level = 1'b1;
          if (!stat.is_unmap && stat.lvl_last_tbl) begin
            state_next = ptw_pkg::S_WL;
          end else begin
            state_next = ptw_pkg::S_RD;
          end
        end
      end
      ptw_pkg::S_WL: begin
        ctl.leaf_map_wr = 1'b1;
        ctl.finish      = 1'b1;
        ctl.fin_status  = ptw_pkg::ST_DONE;
        state_next      = ptw_pkg::S_IDLE;
      end
      default: begin
        state_next = ptw_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ptw_chk.sv @@
// Port-level checker for the page table walker, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ptw_chk (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input ptw_pkg::rsp_t rsp
);

  logic acc;
  logic fail;

  assign acc  = start && !busy;
  assign fail = (rsp.status != ptw_pkg::ST_DONE);

  `AST_NEXT(a_accept_busy, clk, rst, acc, busy)
  `AST_SAME(a_done_idle, clk, rst, done, !busy)
  `AST_SAME(a_fail_quiet, clk, rst, done && fail, !rsp.invalidate && (rsp.old_phys == '0))
  `AST_SAME(a_inv_status, clk, rst, done && rsp.invalidate, !fail)
  `AST_SAME(a_status_range, clk, rst, done, rsp.status <= ptw_pkg::ST_BAD_PTR)

endmodule

bind page_table_map_unmap_walker_top ptw_chk u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

@@ tb/page_table_checker.sv @@
// Checker that predicts and compares every page table walker result.
`timescale 1ns / 1ps
module page_table_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  ptw_pkg::req_t       req,
  input  logic                done,
  input  ptw_pkg::rsp_t       rsp,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [51:0]         cfg_data,
  output int                  errors,
  output int                  outstanding
);

  logic [63:0] frame_entries [ptw_pkg::DEPTH];
  logic [ptw_pkg::NFF_W-1:0] frames_used;
  logic [51:0] root_base;
  ptw_pkg::rsp_t expected_rsp [$];
  ptw_pkg::rsp_t want;

  function automatic logic locate_frame(input logic [63:0] entry,
                                        output logic [ptw_pkg::FRAME_W-1:0] frame);
    logic [51:0] addr;
    logic [51:0] off;
    addr = {entry[51:12], 12'h000};
    frame = '0;
    locate_frame = 1'b0;
    if (addr >= root_base) begin
      off = (addr - root_base) >> 12;
      if (off < frames_used) begin
        frame = off[ptw_pkg::FRAME_W-1:0];
        locate_frame = 1'b1;
      end
    end
  endfunction

  function automatic logic [2:0] map_page(input logic [47:0] va, input logic [51:0] pa,
                                          input logic [63:0] fl);
    logic [ptw_pkg::FRAME_W-1:0] frame;
    logic [ptw_pkg::ADDR_W-1:0] s;
    logic [63:0] e;
    logic [51:0] fresh;
    int lvl;
    frame = '0;
    for (lvl = 0; lvl < 3; lvl++) begin
      s = {frame, va[39 - 9 * lvl +: 9]};
      e = frame_entries[s];
      if (lvl > 0 && e[ptw_pkg::BIT_P] && e[ptw_pkg::BIT_PS]) return ptw_pkg::ST_HUGE;
      if (!e[ptw_pkg::BIT_P]) begin
        if (frames_used >= ptw_pkg::POOL_FRAMES) return ptw_pkg::ST_NO_FRAMES;
        fresh = root_base + {33'd0, frames_used, 12'h000};
        frames_used++;
        e = {12'h000, fresh} | (64'd1 << ptw_pkg::BIT_P) | (64'd1 << ptw_pkg::BIT_W);
        frame_entries[s] = e;
      end
      if (!locate_frame(e, frame)) return ptw_pkg::ST_BAD_PTR;
    end
    frame_entries[{frame, va[20:12]}] = {12'h000, pa[51:12], 12'h000} | fl;
    return ptw_pkg::ST_DONE;
  endfunction

  function automatic logic [2:0] unmap_page(input logic [47:0] va, output logic [51:0] old);
    logic [ptw_pkg::FRAME_W-1:0] frame;
    logic [ptw_pkg::ADDR_W-1:0] s;
    logic [63:0] e;
    int lvl;
    frame = '0;
    old = '0;
    for (lvl = 0; lvl < 3; lvl++) begin
      e = frame_entries[{frame, va[39 - 9 * lvl +: 9]}];
      if (!e[ptw_pkg::BIT_P]) return ptw_pkg::ST_UNMAPPED;
      if (lvl > 0 && e[ptw_pkg::BIT_PS]) return ptw_pkg::ST_HUGE_BLOCK;
      if (!locate_frame(e, frame)) return ptw_pkg::ST_BAD_PTR;
    end
    s = {frame, va[20:12]};
    if (!frame_entries[s][ptw_pkg::BIT_P]) return ptw_pkg::ST_UNMAPPED;
    old = {frame_entries[s][51:12], 12'h000};
    frame_entries[s] = '0;
    return ptw_pkg::ST_DONE;
  endfunction

  function automatic ptw_pkg::rsp_t walk_tables(input ptw_pkg::req_t r);
    ptw_pkg::rsp_t p;
    logic [51:0] old;
    logic ok;
    old = '0;
    if (r.cmd == ptw_pkg::CMD_UNMAP) begin
      p.status = unmap_page(r.vaddr, old);
    end else begin
      p.status = map_page(r.vaddr, r.paddr, r.flags);
    end
    ok = (p.status == ptw_pkg::ST_DONE);
    p.old_phys = ok ? old : '0;
    p.invalidate = ok;
    p.invalidate_addr = ok ? r.vaddr : '0;
    return p;
  endfunction

  task automatic check_field(input string field, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (act_val !== exp_val) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, field, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ptw_pkg::DEPTH; i++) frame_entries[i] = '0;
      frames_used = ptw_pkg::NFF_W'(1);
      root_base = '0;
      expected_rsp.delete();
      errors = 0;
    end else begin
      if (done) begin
        if (expected_rsp.size() == 0) begin
          errors++;
          $display("%0t: result with no request waiting, expected none actual %h",
                   $time, rsp);
        end else begin
          want = expected_rsp.pop_front();
          check_field("status", 64'(want.status), 64'(rsp.status));
          check_field("old_phys", 64'(want.old_phys), 64'(rsp.old_phys));
          check_field("invalidate", 64'(want.invalidate), 64'(rsp.invalidate));
          check_field("invalidate_addr", 64'(want.invalidate_addr),
                      64'(rsp.invalidate_addr));
        end
      end
      if (cfg_valid && cfg_ready) root_base = {cfg_data[51:12], 12'h000};
      if (start && !busy) expected_rsp.push_back(walk_tables(req));
    end
    outstanding = expected_rsp.size();
  end

endmodule

@@ tb/testbench.sv @@
// Testbench top: drives map and unmap requests and pool base writes, gives the verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int WATCHDOG_CYCLES = 100000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  ptw_pkg::req_t req = '0;
  logic          done;
  ptw_pkg::rsp_t rsp;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [51:0]   cfg_data = '0;
  int            errors;
  int            outstanding;
  int            idle_cycles = 0;
  int            sent = 0;
  logic [51:0]   base_now = '0;

  page_table_map_unmap_walker_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  page_table_checker table_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic ptw_pkg::req_t page_req(input logic op, input logic [8:0] i0,
                                             input logic [8:0] i1, input logic [8:0] i2,
                                             input logic [8:0] i3, input logic [51:0] pa,
                                             input logic [63:0] fl);
    ptw_pkg::req_t r;
    r.cmd = op;
    r.vaddr = {i0, i1, i2, i3, 12'($urandom)};
    r.paddr = pa;
    r.flags = fl;
    return r;
  endfunction

  function automatic logic [8:0] pick_index(input int hot_limit);
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) begin
      case (r % 4)
        0: return 9'd0;
        1: return 9'd1;
        2: return 9'd5;
        default: return 9'd511;
      endcase
    end
    return 9'($urandom_range(0, hot_limit));
  endfunction

  function automatic ptw_pkg::req_t random_req();
    logic [51:0] pa;
    logic [63:0] fl;
    logic [8:0] leaf;
    case ($urandom_range(0, 3))
      0, 1: pa = 52'({$urandom, $urandom});
      2: pa = base_now + (52'($urandom_range(0, 63)) << 12);
      default: pa = 52'($urandom_range(0, 255)) << 12;
    endcase
    if ($urandom_range(0, 9) < 4) begin
      fl = {$urandom, $urandom};
    end else begin
      fl = 64'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0) fl[ptw_pkg::BIT_P] = 1'b1;
    end
    leaf = ($urandom_range(0, 9) < 6) ? 9'($urandom_range(0, 7)) : 9'($urandom_range(0, 511));
    return page_req(1'($urandom_range(0, 1)), pick_index(511), pick_index(511),
                    pick_index(511), leaf, pa, fl);
  endfunction

  function automatic int pick_gap();
    int r;
    if (sent % 64 < 16) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(5, 40);
  endfunction

  task automatic send(input ptw_pkg::req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent++;
  endtask

  task automatic set_base(input logic [51:0] value);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    base_now = {value[51:12], 12'h000};
  endtask

  task automatic run_phase(input logic [51:0] value, input int count);
    set_base(value);
    repeat (count) send(random_req());
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    set_base(52'h0);
    send(page_req(ptw_pkg::CMD_UNMAP, 9'd1, 9'd0, 9'd0, 9'd0, 52'h0, 64'h0));
    send(page_req(ptw_pkg::CMD_MAP, 9'd1, 9'd0, 9'd0, 9'd0, 52'hF_FFFF_FFFF_FFFF, 64'h3));
    send(page_req(ptw_pkg::CMD_UNMAP, 9'd1, 9'd0, 9'd0, 9'd1, 52'h0, 64'h0));
    send(page_req(ptw_pkg::CMD_UNMAP, 9'd1, 9'd1, 9'd0, 9'd0, 52'h0, 64'h0));
    send(page_req(ptw_pkg::CMD_UNMAP, 9'd1, 9'd0, 9'd1, 9'd0, 52'h0, 64'h0));
    send(page_req(ptw_pkg::CMD_UNMAP, 9'd1, 9'd0, 9'd0, 9'd0, 52'h0, 64'h0));
    send(page_req(ptw_pkg::CMD_MAP, 9'd1, 9'd0, 9'd0, 9'd2, 52'h0,
                  64'hFFFF_FFFF_FFFF_FFFF));
    send(page_req(ptw_pkg::CMD_UNMAP, 9'd1, 9'd0, 9'd0, 9'd2, 52'h0, 64'h0));
    send(page_req(ptw_pkg::CMD_MAP, 9'd511, 9'd511, 9'd511, 9'd511,
                  52'({$urandom, $urandom}), 64'h0));
    send(page_req(ptw_pkg::CMD_UNMAP, 9'd511, 9'd511, 9'd511, 9'd511, 52'h0, 64'h0));

    // With the base one frame up, root entry 1 points back at the root table,
    // so leaf writes through it land in the root and can fake huge pages.
    set_base(52'h1ABC);
    send(page_req(ptw_pkg::CMD_MAP, 9'd1, 9'd1, 9'd1, 9'd5, 52'h0, 64'h81));
    send(page_req(ptw_pkg::CMD_MAP, 9'd1, 9'd5, 9'd0, 9'd0, 52'h0, 64'h3));
    send(page_req(ptw_pkg::CMD_UNMAP, 9'd1, 9'd5, 9'd0, 9'd0, 52'h0, 64'h0));
    send(page_req(ptw_pkg::CMD_MAP, 9'd1, 9'd1, 9'd5, 9'd0, 52'h0, 64'h3));
    send(page_req(ptw_pkg::CMD_UNMAP, 9'd1, 9'd1, 9'd5, 9'd0, 52'h0, 64'h0));
    send(page_req(ptw_pkg::CMD_MAP, 9'd1, 9'd1, 9'd1, 9'd6, 52'h0, 64'h1));
    send(page_req(ptw_pkg::CMD_MAP, 9'd1, 9'd6, 9'd0, 9'd0, 52'h0, 64'h3));
    send(page_req(ptw_pkg::CMD_MAP, 9'd1, 9'd1, 9'd1, 9'd7, 52'h40000, 64'h1));
    send(page_req(ptw_pkg::CMD_UNMAP, 9'd1, 9'd7, 9'd0, 9'd0, 52'h0, 64'h0));
    send(page_req(ptw_pkg::CMD_MAP, 9'd1, 9'd1, 9'd1, 9'd9, 52'h1000, 64'h83));
    send(page_req(ptw_pkg::CMD_MAP, 9'd9, 9'd1, 9'd1, 9'd3, 52'h7_7777_7777_7000, 64'h3));
    send(page_req(ptw_pkg::CMD_UNMAP, 9'd1, 9'd1, 9'd1, 9'd5, 52'h0, 64'h0));

    // A new frame address past the top of the 52-bit space wraps below the base.
    set_base(52'hF_FFFF_FFFF_FFFF);
    send(page_req(ptw_pkg::CMD_MAP, 9'd200, 9'd0, 9'd0, 9'd0, 52'h0, 64'h3));

    run_phase(52'h0, 250);
    run_phase(52'h1000, 200);
    run_phase(52'({$urandom, $urandom}), 60);
    run_phase(52'h2FFF, 150);
    run_phase(52'h0, 200);
    run_phase(52'hF_FFFF_FFFF_FFFF, 30);
    run_phase(52'h1000, 140);

    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ptw_pkg.sv
rtl/ptw_dp.sv
rtl/ptw_ctrl.sv
rtl/page_table_map_unmap_walker_top.sv
rtl/ptw_chk.sv
tb/page_table_checker.sv
tb/testbench.sv
